// File: rtl/trm_pkg.sv
`default_nettype none
package trm_pkg;
  localparam int MemBytes = 4096;
  localparam int AddrW = $clog2(MemBytes);
  localparam int RegCount = 9;
  localparam int RegIdxW = $clog2(RegCount);

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd1;
  localparam logic [1:0] KIND_EXEC = 2'd2;

  localparam logic [31:0] OP_JMP = 32'd1;
  localparam logic [31:0] OP_MOV = 32'd7;
  localparam logic [31:0] OP_STR = 32'd9;
  localparam logic [31:0] OP_LDR = 32'd10;
  localparam logic [31:0] OP_LDB = 32'd12;
  localparam logic [31:0] OP_ADD = 32'd13;
  localparam logic [31:0] OP_SUB = 32'd15;
  localparam logic [31:0] OP_MUL = 32'd16;
  localparam logic [31:0] OP_DIV = 32'd17;
  localparam logic [31:0] OP_TRP = 32'd21;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_CHAR = 3'd1;
  localparam logic [2:0] ST_INT = 3'd2;
  localparam logic [2:0] ST_HALT = 3'd3;
  localparam logic [2:0] ST_END = 3'd4;
  localparam logic [2:0] ST_FAULT = 3'd5;

  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_END = 2'd1;

  // datapath commands
  localparam logic [2:0] DC_NONE = 3'd0;
  localparam logic [2:0] DC_FETCH = 3'd1; // capture byte into word buffer
  localparam logic [2:0] DC_STORE = 3'd2; // write byte of register to memory
  localparam logic [2:0] DC_ALU = 3'd3;
  localparam logic [2:0] DC_DIV = 3'd4;
  localparam logic [2:0] DC_LOADB = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] word_sel; // 0 opcode, 1 A, 2 B, 3 data
    logic [1:0] byte_sel;
    logic div_start;
  } dp_cmd_t;

  typedef struct packed {
    logic [31:0] opw;
    logic [31:0] aw;
    logic [31:0] bw;
    logic div_busy;
    logic div_zero;
  } dp_stat_t;
endpackage
`default_nettype wire

// File: rtl/trm_ram.sv
`default_nettype none
module trm_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/trm_div.sv
`default_nettype none
module trm_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             busy,
  output logic      [31:0] quo
);
  import trm_pkg::*;
  logic [31:0] rem_r, rem_nxt, q_r, q_nxt, d_r, d_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic neg_r, neg_nxt;
  logic [32:0] trial;
  logic [31:0] shifted;

  assign busy = (cnt_r != 6'd0);
  assign quo = neg_r ? (32'd0 - q_r) : q_r;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt = q_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    shifted = {rem_r[30:0], q_r[31]};
    trial = {1'b0, shifted} - {1'b0, d_r};
    if (start) begin
      rem_nxt = 32'd0;
      q_nxt = num[31] ? (32'd0 - num) : num;
      d_nxt = den[31] ? (32'd0 - den) : den;
      neg_nxt = num[31] ^ den[31];
      cnt_nxt = 6'd32;
    end else if (busy) begin
      // one restoring step per cycle
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    d_r <= d_nxt;
    neg_r <= neg_nxt;
  end
endmodule
`default_nettype wire

// File: rtl/trm_datapath.sv
`default_nettype none
module trm_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire trm_pkg::dp_cmd_t        cmd,
  input  wire logic [7:0]              mem_rdata,
  output trm_pkg::dp_stat_t            stat,
  output logic      [7:0]              store_byte,
  output logic      [31:0]             reg1,
  output logic      [31:0]             reg3
);
  import trm_pkg::*;
  logic [31:0] regs_r [RegCount];
  logic [31:0] w_r [4];
  logic [31:0] ra, rb, res, prod;
  logic [RegIdxW-1:0] ia, ib;
  logic [31:0] quo;
  logic dbusy;

  trm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(ra), .den(rb), .busy(dbusy), .quo(quo)
  );

  assign ia = w_r[1][RegIdxW-1:0];
  assign ib = w_r[2][RegIdxW-1:0];
  assign ra = regs_r[ia];
  assign rb = regs_r[ib];
  assign prod = ra * rb;
  assign reg1 = regs_r[1];
  assign reg3 = regs_r[3];
  assign store_byte = ra[cmd.byte_sel*8 +: 8];
  assign stat.opw = w_r[0];
  assign stat.aw = w_r[1];
  assign stat.bw = w_r[2];
  assign stat.div_busy = dbusy;
  assign stat.div_zero = (rb == 32'd0);

  always_comb begin
    res = ra;
    case (w_r[0])
      OP_ADD: res = ra + rb;
      OP_SUB: res = ra - rb;
      OP_MUL: res = prod;
      OP_MOV: res = rb;
      OP_LDR: res = w_r[3];
      default: res = ra;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RegCount; i++) begin
        regs_r[i] <= 32'd0;
      end
    end else begin
      case (cmd.op)
        DC_ALU: regs_r[ia] <= res;
        DC_DIV: regs_r[ia] <= quo;
        DC_LOADB: regs_r[ia] <= {{24{w_r[3][7]}}, w_r[3][7:0]};
        default: ;
      endcase
    end
    if (cmd.op == DC_FETCH) begin
      w_r[cmd.word_sel][cmd.byte_sel*8 +: 8] <= mem_rdata;
    end
  end
endmodule
`default_nettype wire

// File: rtl/trm_ctrl.sv
`default_nettype none
module trm_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [1:0]                  kind,
  input  wire logic [trm_pkg::AddrW-1:0]   address,
  input  wire logic [7:0]                  load_byte,
  input  wire logic [trm_pkg::AddrW-1:0]   start_addr,
  input  wire logic [trm_pkg::AddrW:0]     end_addr,
  input  wire trm_pkg::dp_stat_t           stat,
  input  wire logic [7:0]                  store_byte,
  input  wire logic [31:0]                 reg1,
  input  wire logic [31:0]                 reg3,
  output trm_pkg::dp_cmd_t                 cmd,
  output logic                             busy,
  output logic                             mem_we,
  output logic      [trm_pkg::AddrW-1:0]   mem_waddr,
  output logic      [7:0]                  mem_wdata,
  output logic      [trm_pkg::AddrW-1:0]   mem_raddr,
  output logic                             done,
  output logic      [2:0]                  status,
  output logic      [31:0]                 value,
  output logic      [trm_pkg::AddrW-1:0]   pc_after
);
  import trm_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1; // instruction words, 12 bytes
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_DATA = 3'd3;  // data read for LDR/LDB
  localparam logic [2:0] S_STORE = 3'd4;
  localparam logic [2:0] S_DIV = 3'd5;
  localparam logic [2:0] S_WB = 3'd6;

  logic [2:0] st_r, st_nxt;
  logic [AddrW-1:0] pc_r, pc_nxt;
  logic halted_r, halted_nxt;
  logic [4:0] cnt_r, cnt_nxt; // issue counter; read data arrives in the cycle after its read
  logic [AddrW-1:0] base_r, base_nxt;
  logic [2:0] stat_r, stat_nxt;
  logic [31:0] val_r, val_nxt;
  logic done_r, done_nxt;
  logic [3:0] issue_n;
  logic [AddrW-1:0] pc_step;
  logic bad_a, bad_b;

  assign busy = (st_r != S_IDLE);
  assign done = done_r;
  assign status = stat_r;
  assign value = val_r;
  assign pc_after = pc_r;
  assign pc_step = pc_r + AddrW'(12);
  assign bad_a = (stat.aw >= 32'(RegCount));
  assign bad_b = (stat.bw >= 32'(RegCount));

  always_comb begin
    st_nxt = st_r;
    pc_nxt = pc_r;
    halted_nxt = halted_r;
    cnt_nxt = cnt_r;
    base_nxt = base_r;
    stat_nxt = stat_r;
    val_nxt = val_r;
    done_nxt = 1'b0;
    cmd = '0;
    mem_we = 1'b0;
    mem_waddr = address;
    mem_wdata = load_byte;
    issue_n = 4'(cnt_r);
    mem_raddr = base_r + AddrW'(issue_n);
    case (st_r)
      S_IDLE: begin
        if (start) begin
          stat_nxt = ST_OK;
          val_nxt = 32'd0;
          case (kind)
            KIND_LOAD: begin
              mem_we = 1'b1;
              done_nxt = 1'b1;
            end
            KIND_RESTART: begin
              pc_nxt = start_addr;
              halted_nxt = 1'b0;
              done_nxt = 1'b1;
            end
            KIND_EXEC: begin
              if (halted_r) begin
                stat_nxt = ST_HALT;
                done_nxt = 1'b1;
              end else if ({1'b0, pc_r} >= end_addr) begin
                stat_nxt = ST_END;
                done_nxt = 1'b1;
              end else begin
                base_nxt = pc_r;
                cnt_nxt = 5'd0;
                st_nxt = S_FETCH;
              end
            end
            default: done_nxt = 1'b1;
          endcase
        end
      end
      S_FETCH: begin
        // cnt_r counts issued reads; capture trails issue by one read
        if (cnt_r != 5'd0) begin
          cmd.op = DC_FETCH;
          cmd.word_sel = 2'((cnt_r - 5'd1) >> 2);
          cmd.byte_sel = 2'(cnt_r - 5'd1);
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd12) begin
          st_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        st_nxt = S_WB;
        case (stat.opw)
          OP_JMP: begin
            pc_nxt = stat.aw[AddrW-1:0];
            done_nxt = 1'b1;
            st_nxt = S_IDLE;
          end
          OP_TRP: begin
            done_nxt = 1'b1;
            st_nxt = S_IDLE;
            if (stat.aw == 32'd0) begin
              halted_nxt = 1'b1;
              stat_nxt = ST_HALT;
            end else if (stat.aw == 32'd1) begin
              stat_nxt = ST_INT;
              val_nxt = reg1;
              pc_nxt = pc_step;
            end else if (stat.aw == 32'd3) begin
              stat_nxt = ST_CHAR;
              val_nxt = {24'd0, reg3[7:0]};
              pc_nxt = pc_step;
            end else begin
              halted_nxt = 1'b1;
              stat_nxt = ST_FAULT;
            end
          end
          OP_LDB, OP_LDR, OP_STR: begin
            base_nxt = stat.bw[AddrW-1:0];
            cnt_nxt = 5'd0;
            if (bad_a) begin
              halted_nxt = 1'b1;
              stat_nxt = ST_FAULT;
              done_nxt = 1'b1;
              st_nxt = S_IDLE;
            end else if (stat.opw == OP_STR) begin
              st_nxt = S_STORE;
            end else begin
              st_nxt = S_DATA;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_MOV, OP_DIV: begin
            if (bad_a || bad_b || (stat.opw == OP_DIV && stat.div_zero)) begin
              halted_nxt = 1'b1;
              stat_nxt = ST_FAULT;
              done_nxt = 1'b1;
              st_nxt = S_IDLE;
            end else if (stat.opw == OP_DIV) begin
              cmd.div_start = 1'b1;
              st_nxt = S_DIV;
            end
          end
          default: begin
            halted_nxt = 1'b1;
            stat_nxt = ST_FAULT;
            done_nxt = 1'b1;
            st_nxt = S_IDLE;
          end
        endcase
      end
      S_DATA: begin
        if (cnt_r != 5'd0) begin
          cmd.op = DC_FETCH;
          cmd.word_sel = 2'd3;
          cmd.byte_sel = 2'(cnt_r - 5'd1);
        end
        cnt_nxt = cnt_r + 5'd1;
        if ((stat.opw == OP_LDB && cnt_r == 5'd1) || cnt_r == 5'd4) begin
          st_nxt = S_WB;
        end
      end
      S_STORE: begin
        cmd.byte_sel = 2'(cnt_r);
        mem_we = 1'b1;
        mem_waddr = base_r + AddrW'(cnt_r[1:0]);
        mem_wdata = store_byte;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd3) begin
          pc_nxt = pc_step;
          done_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          cmd.op = DC_DIV;
          pc_nxt = pc_step;
          done_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      S_WB: begin
        cmd.op = (stat.opw == OP_LDB) ? DC_LOADB : DC_ALU;
        pc_nxt = pc_step;
        done_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pc_r <= '0;
      halted_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pc_r <= pc_nxt;
      halted_r <= halted_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    base_r <= base_nxt;
    stat_r <= stat_nxt;
    val_r <= val_nxt;
  end
endmodule
`default_nettype wire

// File: rtl/tiny_register_machine_step.sv
`default_nettype none
// Tiny register machine, one instruction per execute command.
// Input: pulse start with in_kind/in_address/in_load_byte while busy is low.
//   kind 0 writes one memory byte, 1 restarts at start_address, 2 executes.
// Config: cfg_we/cfg_index/cfg_wdata; index 0 start_address, 1 end_address.
//   Write only while idle.
// Output: out_valid strobes for one cycle with out_status, out_value and
//   out_pc_after. Exactly one beat per accepted command; the receiver
//   cannot stall, so it must sample on the strobe.
// Sequence: load, restart and trivial execute commands answer from idle.
//   An executed instruction fetches 12 bytes through the single byte-wide
//   memory read port and decodes, so JMP, TRP and faults answer after
//   decode; then LDB and LDR read one and four data bytes and write back,
//   STR writes four bytes, ALU writes back and DIV waits on the divider
//   (one quotient bit per cycle). Busy is high throughout.
// One command at a time: the next start is taken once busy falls.
// Reset: registers, pc and halted clear, start_address 0, end_address 4096.
//   Program memory is not cleared; it is undefined until loaded.
module tiny_register_machine_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_kind,
  input  wire logic [11:0]        in_address,
  input  wire logic [7:0]         in_load_byte,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [12:0]        cfg_wdata,
  output logic                    out_valid,
  output logic      [2:0]         out_status,
  output logic signed [31:0]      out_value,
  output logic      [11:0]        out_pc_after
);
  import trm_pkg::*;
  logic [AddrW-1:0] start_addr_r;
  logic [AddrW:0] end_addr_r;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [7:0] store_byte, mem_rdata, mem_wdata;
  logic [31:0] reg1, reg3, val;
  logic mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= '0;
      end_addr_r <= (AddrW+1)'(MemBytes);
    end else if (cfg_we) begin
      if ({1'b0, cfg_index} == CFG_START) begin
        start_addr_r <= cfg_wdata[AddrW-1:0];
      end else begin
        end_addr_r <= cfg_wdata[AddrW:0];
      end
    end
  end

  trm_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  trm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .mem_rdata(mem_rdata), .stat(stat),
    .store_byte(store_byte), .reg1(reg1), .reg3(reg3)
  );

  trm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .kind(in_kind),
    .address(in_address), .load_byte(in_load_byte),
    .start_addr(start_addr_r), .end_addr(end_addr_r), .stat(stat),
    .store_byte(store_byte), .reg1(reg1), .reg3(reg3), .cmd(cmd), .busy(busy),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr), .done(out_valid), .status(out_status),
    .value(val), .pc_after(out_pc_after)
  );
  assign out_value = signed'(val);

  // a result never appears while a command is still running
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(busy) || !busy) else $error("result while busy");
  // idle start produces a result or busy next cycle
  a_start_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy)) else $error("start dropped");
  // no result without a preceding command
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !(start)) |=> !out_valid) else $error("spurious result");
endmodule
`default_nettype wire
